// ===== design/iee_pkg.sv =====
// iee_pkg: shared types, character codes and helpers for the infix expression evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package iee_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_PLUS  = 3'd0,
    OP_MINUS = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NONE  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DIV,
    ST_DIV_END,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              final_char;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     div_zero;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic apply;
    logic div_start;
    logic div_step;
    logic div_end;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_apply;
    logic last;
    logic div_busy;
    logic div_last;
  } dp_status_t;

  function automatic op_e op_code(input logic [CHAR_W-1:0] c);
    op_e op;
    unique case (c)
      CH_PLUS:  op = OP_PLUS;
      CH_MINUS: op = OP_MINUS;
      CH_MUL:   op = OP_MUL;
      CH_DIV:   op = OP_DIV;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== design/iee_ctrl.sv =====
// iee_ctrl: sequencer for the evaluator, issues commands to the datapath
// depends on iee_pkg for state, command and status types
`default_nettype none

module iee_ctrl import iee_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.need_apply) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (status_i.div_busy) state_d = ST_DIV;
        else if (status_i.last) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_DIV_END;
      end
      ST_DIV_END: begin
        state_d = status_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_APPLY: begin
        cmd_o.div_start = status_i.div_busy;
        cmd_o.apply     = !status_i.div_busy;
      end
      ST_DIV:     cmd_o.div_step = 1'b1;
      ST_DIV_END: cmd_o.div_end  = 1'b1;
      ST_EMIT:    cmd_o.emit     = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/iee_dpath.sv =====
// iee_dpath: expression state, number accumulator, multiplier and bit-serial divider
// depends on iee_pkg for types, character codes and op decoding
`default_nettype none

module iee_dpath import iee_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     status_o,
  output out_item_t      out_item_o
);

  logic [DATA_W-1:0]    sum_q, sum_d;
  logic [DATA_W-1:0]    term_q, term_d;
  logic [DATA_W-1:0]    num_q, num_d;
  op_e                  pend_op_q, pend_op_d;
  op_e                  next_op_q;
  logic                 err_q, err_d;
  logic                 last_q;

  logic [DATA_W-1:0]    rem_q, quo_q, dvsr_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  out_item_t            out_q;

  logic                 digit;
  logic [DATA_W-1:0]    digit_val;
  logic [DATA_W-1:0]    rem_shift;
  logic [DATA_W:0]      rem_diff;
  logic [DATA_W-1:0]    term_abs, num_abs;
  logic [DATA_W-1:0]    product;

  assign digit     = is_digit(in_item_i.character);
  assign digit_val = {{(DATA_W-CHAR_W){1'b0}}, in_item_i.character - CH_ZERO};
  assign product   = term_q * num_q;
  assign term_abs  = term_q[DATA_W-1] ? (~term_q + 1'b1) : term_q;
  assign num_abs   = num_q[DATA_W-1] ? (~num_q + 1'b1) : num_q;
  assign rem_shift = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {1'b0, dvsr_q};

  always_comb begin
    sum_d     = sum_q;
    term_d    = term_q;
    num_d     = num_q;
    pend_op_d = pend_op_q;
    err_d     = err_q;
    if (cmd_i.accept && digit) begin
      num_d = {num_q[DATA_W-4:0], 3'b000} + {num_q[DATA_W-2:0], 1'b0} + digit_val;
    end
    if (cmd_i.apply) begin
      case (pend_op_q)
        OP_PLUS: begin
          sum_d  = sum_q + term_q;
          term_d = num_q;
        end
        OP_MINUS: begin
          sum_d  = sum_q + term_q;
          term_d = ~num_q + 1'b1;
        end
        OP_MUL: term_d = product;
        OP_DIV: begin
          term_d = '0;
          err_d  = 1'b1;
        end
        default: ;
      endcase
      num_d     = '0;
      pend_op_d = next_op_q;
    end
    if (cmd_i.div_end) begin
      term_d    = neg_q ? (~quo_q + 1'b1) : quo_q;
      num_d     = '0;
      pend_op_d = next_op_q;
    end
    if (cmd_i.emit) begin
      sum_d     = '0;
      term_d    = '0;
      num_d     = '0;
      pend_op_d = OP_PLUS;
      err_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      term_q    <= '0;
      num_q     <= '0;
      pend_op_q <= OP_PLUS;
      err_q     <= 1'b0;
      next_op_q <= OP_PLUS;
      last_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      sum_q     <= sum_d;
      term_q    <= term_d;
      num_q     <= num_d;
      pend_op_q <= pend_op_d;
      err_q     <= err_d;
      if (cmd_i.accept) begin
        next_op_q <= op_code(in_item_i.character);
        last_q    <= in_item_i.final_char;
      end
      if (cmd_i.div_start) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= term_abs;
      dvsr_q <= num_abs;
      neg_q  <= term_q[DATA_W-1] ^ num_q[DATA_W-1];
    end else if (cmd_i.div_step) begin
      if (!rem_diff[DATA_W]) begin
        rem_q <= rem_diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_q.value    <= sum_q + term_q;
      out_q.div_zero <= err_q;
    end
  end

  assign status_o.need_apply = ((in_item_i.character != CH_SPACE) && !digit)
                               || in_item_i.final_char;
  assign status_o.last       = last_q;
  assign status_o.div_busy   = (pend_op_q == OP_DIV) && (num_q != '0);
  assign status_o.div_last   = (cnt_q == DIV_CNT_W'(DATA_W-1));
  assign out_item_o          = out_q;

endmodule

`default_nettype wire

// ===== design/infix_expression_evaluator.sv =====
// Infix expression evaluator: takes one ASCII character per item and returns one result item
// on the character marked final. A digit or space that is not final is taken while the block
// stays ready. An operator, an unknown character or the final character applies the pending
// number in the apply state; for / with a nonzero divisor the divide and divide-end states of
// the restoring divider, one quotient bit per cycle, follow. The final character then loads
// the output register, which holds the result while the next expression is being read.
// depends on iee_pkg, iee_ctrl and iee_dpath
`default_nettype none

module infix_expression_evaluator import iee_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  iee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  iee_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== design/iee_checker.sv =====
// iee_checker: port-level assertions for the evaluator, bound to the top level
// depends on iee_pkg and infix_expression_evaluator
`default_nettype none

module iee_checker import iee_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // a stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item dropped or changed while stalled");

  // a final character always leads to an apply step
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.final_char |=> !in_ready_o)
    else $error("final item taken without apply step");

  // a plain digit that is not final leaves the input ready for the next item
  a_digit_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_item_i.final_char
    && (in_item_i.character >= CH_ZERO) && (in_item_i.character <= CH_NINE) |=> in_ready_o)
    else $error("digit item stalled the input");

  // a result only appears after the block has been busy
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an emit step");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);

`default_nettype wire

// ===== sim/infix_expression_evaluator_test.sv =====
// testbench for infix_expression_evaluator: sends expressions one character item at a time
// and checks each result item against a built-in evaluator of the same arithmetic
// depends on iee_pkg and the infix_expression_evaluator rtl
`default_nettype none

module infix_expression_evaluator_test import iee_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  infix_expression_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  int unsigned idle_pct = 19;
  int unsigned n_sent = 0;
  int unsigned n_errors = 0;

  logic [DATA_W-1:0] run_sum = '0;
  logic [DATA_W-1:0] cur_term = '0;
  logic [DATA_W-1:0] num_acc = '0;
  op_e               pend_op = OP_PLUS;
  logic              div_err = 1'b0;
  out_item_t         expected_results[$];
  out_item_t         oldest_result;

  function automatic op_e char_to_op(input logic [CHAR_W-1:0] c);
    case (c)
      CH_PLUS:  return OP_PLUS;
      CH_MINUS: return OP_MINUS;
      CH_MUL:   return OP_MUL;
      CH_DIV:   return OP_DIV;
      default:  return OP_NONE;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] quot_toward_zero(input logic [DATA_W-1:0] a,
                                                          input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] q;
    mag_a = a[DATA_W-1] ? ('0 - a) : a;
    mag_b = b[DATA_W-1] ? ('0 - b) : b;
    q = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? ('0 - q) : q;
  endfunction

  function automatic void apply_number();
    case (pend_op)
      OP_PLUS: begin
        run_sum = run_sum + cur_term;
        cur_term = num_acc;
      end
      OP_MINUS: begin
        run_sum = run_sum + cur_term;
        cur_term = '0 - num_acc;
      end
      OP_MUL: cur_term = cur_term * num_acc;
      OP_DIV: begin
        if (num_acc == '0) begin
          cur_term = '0;
          div_err = 1'b1;
        end else begin
          cur_term = quot_toward_zero(cur_term, num_acc);
        end
      end
      default: ;
    endcase
    num_acc = '0;
  endfunction

  function automatic void eval_char(input in_item_t it);
    logic      digit;
    out_item_t r;
    digit = (it.character >= CH_ZERO) && (it.character <= CH_NINE);
    if (digit) begin
      num_acc = num_acc * 32'd10 + DATA_W'(it.character - CH_ZERO);
    end
    if ((it.character != CH_SPACE && !digit) || it.final_char) begin
      apply_number();
      pend_op = char_to_op(it.character);
    end
    if (it.final_char) begin
      r.value = run_sum + cur_term;
      r.div_zero = div_err;
      expected_results.push_back(r);
      run_sum = '0;
      cur_term = '0;
      num_acc = '0;
      pend_op = OP_PLUS;
      div_err = 1'b0;
    end
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    in_item_t it;
    it.character = c;
    it.final_char = last;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    eval_char(it);
    n_sent++;
  endtask

  task automatic send_expr(input logic [CHAR_W-1:0] chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [CHAR_W-1:0] chars[$];
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_expr(chars);
  endtask

  task automatic add_number(ref logic [CHAR_W-1:0] chars[$]);
    int unsigned r;
    int unsigned n_digits;
    r = $urandom_range(99);
    if (r < 10) n_digits = 0;
    else if (r < 80) n_digits = $urandom_range(1, 3);
    else if (r < 95) n_digits = $urandom_range(4, 9);
    else n_digits = $urandom_range(10, 12);
    repeat (n_digits) chars.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
  endtask

  task automatic add_operator(ref logic [CHAR_W-1:0] chars[$]);
    case ($urandom_range(3))
      0: chars.push_back(CH_PLUS);
      1: chars.push_back(CH_MINUS);
      2: chars.push_back(CH_MUL);
      default: chars.push_back(CH_DIV);
    endcase
  endtask

  task automatic send_random_expr();
    logic [CHAR_W-1:0] chars[$];
    int unsigned n_terms;
    if ($urandom_range(9) == 0) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(1, 6)) chars.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      n_terms = $urandom_range(1, 5);
      for (int t = 0; t < n_terms; t++) begin
        if ($urandom_range(9) == 0) chars.push_back(CH_SPACE);
        add_number(chars);
        if ($urandom_range(9) == 0) chars.push_back(CH_SPACE);
        if (t < n_terms - 1) begin
          if ($urandom_range(99) < 8) chars.push_back(CHAR_W'($urandom_range(255)));
          else add_operator(chars);
        end
      end
      case ($urandom_range(9))
        0: add_operator(chars);
        1: chars.push_back(CH_SPACE);
        2: chars.push_back(CHAR_W'($urandom_range(255)));
        default: ;
      endcase
      if (chars.size() == 0) chars.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
    end
    send_expr(chars);
  endtask

  task automatic test_directed();
    // most negative term divided by minus one wraps to itself
    send_text("-2147483648/4294967295");
    // unknown char drops the next number, zero divisor, operator as last char
    send_text("3 *7a5/0+");
    // zero divisor applied by the last char
    send_text("9/0");
  endtask

  task automatic test_random_expressions(input int unsigned upto);
    idle_pct = 19;
    while (n_sent < upto) send_random_expr();
  endtask

  task automatic test_back_to_back(input int unsigned upto);
    idle_pct = 0;
    while (n_sent < upto) send_random_expr();
    idle_pct = 19;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected result item: value %0d div_zero %0b",
                   out_item_o.value, out_item_o.div_zero);
        end
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_item_o.value !== oldest_result.value ||
            out_item_o.div_zero !== oldest_result.div_zero) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: expected value %0d div_zero %0b, got value %0d div_zero %0b",
                     oldest_result.value, oldest_result.div_zero,
                     out_item_o.value, out_item_o.div_zero);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_expressions(1000);
    test_back_to_back(1400);
    test_random_expressions(1750);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/iee_pkg.sv
design/iee_ctrl.sv
design/iee_dpath.sv
design/infix_expression_evaluator.sv
design/iee_checker.sv
sim/infix_expression_evaluator_test.sv
